// ===== sv/keyword_substitution_cipher_assert.svh =====
// ----------------------------------------------------------------------------
// keyword substitution cipher assertion macros
// concurrent property helpers for the checker
// ----------------------------------------------------------------------------
`ifndef KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH

// same-cycle implication
`define KWSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KWSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/kwsc_pkg.sv =====
// ----------------------------------------------------------------------------
// kwsc_pkg
// shared types and constants of the keyword substitution cipher
// ----------------------------------------------------------------------------
package kwsc_pkg;

    typedef logic [1:0] t_mode;
    typedef logic [4:0] t_letter;
    typedef logic [7:0] t_byte;

    localparam t_mode MODE_KEY  = 2'd0;
    localparam t_mode MODE_END  = 2'd1;
    localparam t_mode MODE_TEXT = 2'd2;

    localparam int      LETTERS      = 26;
    localparam t_letter LETTER_COUNT = 5'd26;
    localparam t_letter LETTER_LAST  = 5'd25;
    localparam t_letter LETTER_FIRST = 5'd0;

    localparam t_byte CH_UPPER_A = 8'h41;
    localparam t_byte CH_UPPER_Z = 8'h5A;
    localparam t_byte CH_LOWER_A = 8'h61;
    localparam t_byte CH_LOWER_Z = 8'h7A;

endpackage

// ===== sv/keyword_substitution_cipher.sv =====
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// monoalphabetic keyword cipher on a byte stream
// ----------------------------------------------------------------------------
// usage:
//   input channel i_in_valid / o_in_stall carries i_mode and i_data_byte.
//   keyword words (mode key) add new letters to the cipher alphabet. an
//   end-of-key word starts the alphabet completion: the fill state sweeps
//   the letters Z down to A through the shared placement unit, then the
//   reverse state builds the reverse map, so the block stalls its input
//   after an end-of-key word until both steps are done.
//   text words are one map lookup: the result appears on the output
//   register in the cycle after acceptance; text streams at one word per
//   cycle unless stalled. keyword and end-of-key words give no result.
//   output channel o_out_valid / i_out_stall carries o_out_byte, o_no_key.
//   while the output word is stalled, the input is stalled too.
//   config channel i_cfg_valid / o_cfg_ready writes decrypt_mode; ready is
//   always high, write only while the block is idle.
//   synchronous reset clears the key, the mode register and the output;
//   text that arrives before a key is completed passes with o_no_key set.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  kwsc_pkg::t_mode   i_mode,
    input  kwsc_pkg::t_byte   i_data_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output kwsc_pkg::t_byte   o_out_byte,
    output logic              o_no_key,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_decrypt_mode
);
    import kwsc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_REV
    } t_state;

    t_state             r_state;
    t_letter            r_cnt;
    logic [LETTERS-1:0] r_seen;
    t_letter            r_fill;
    logic               r_key_ready;
    logic               r_decrypt;
    t_letter            r_fwd [LETTERS];
    t_letter            r_rev [LETTERS];
    logic               r_out_valid;
    t_byte              r_out_byte;
    logic               r_no_key;

    logic               in_accept;
    logic               is_upper;
    logic               is_lower;
    logic               is_alpha;
    t_byte              letter_diff;
    t_letter            letter_idx;
    t_letter            sub;
    t_byte              text_res;

    t_letter            pl_letter;
    logic               pl_en;
    logic               pl_hit;
    logic [LETTERS-1:0] seen_base;
    t_letter            fill_base;
    logic [LETTERS-1:0] n_seen;
    t_letter            n_fill;

    assign o_in_stall  = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_no_key    = r_no_key;

    // letter decode, shared by keyword folding and text lookup
    always_comb begin
        is_upper    = (i_data_byte >= CH_UPPER_A) && (i_data_byte <= CH_UPPER_Z);
        is_lower    = (i_data_byte >= CH_LOWER_A) && (i_data_byte <= CH_LOWER_Z);
        is_alpha    = is_upper || is_lower;
        letter_diff = is_lower ? (i_data_byte - CH_LOWER_A) : (i_data_byte - CH_UPPER_A);
        letter_idx  = letter_diff[4:0];
        sub         = r_decrypt ? r_rev[letter_idx] : r_fwd[letter_idx];
        if (!r_key_ready || !is_alpha) begin
            text_res = i_data_byte;
        end else if (is_lower) begin
            text_res = {3'b000, sub} + CH_LOWER_A;
        end else begin
            text_res = {3'b000, sub} + CH_UPPER_A;
        end
    end

    // shared placement unit: append a letter if unseen and room is left
    always_comb begin
        pl_letter = (r_state == ST_FILL) ? r_cnt : letter_idx;
        pl_en     = (r_state == ST_FILL)
                 || (in_accept && (i_mode == MODE_KEY) && is_alpha);
        seen_base = (r_state == ST_IDLE && r_key_ready) ? '0 : r_seen;
        fill_base = (r_state == ST_IDLE && r_key_ready) ? LETTER_FIRST : r_fill;
        pl_hit    = pl_en && !seen_base[pl_letter] && (fill_base < LETTER_COUNT);
        n_seen    = seen_base;
        n_fill    = fill_base;
        if (pl_hit) begin
            n_seen[pl_letter] = 1'b1;
            n_fill            = fill_base + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= LETTER_FIRST;
            r_seen      <= '0;
            r_fill      <= LETTER_FIRST;
            r_key_ready <= 1'b0;
            r_decrypt   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_decrypt <= i_cfg_decrypt_mode;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (pl_hit) begin
                r_fwd[fill_base] <= pl_letter;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        unique case (i_mode)
                            MODE_KEY: begin
                                r_seen      <= n_seen;
                                r_fill      <= n_fill;
                                r_key_ready <= 1'b0;
                            end
                            MODE_END: begin
                                r_state <= ST_FILL;
                                r_cnt   <= LETTER_LAST;
                            end
                            MODE_TEXT: begin
                                r_out_valid <= 1'b1;
                                r_out_byte  <= text_res;
                                r_no_key    <= !r_key_ready;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_FILL: begin
                    r_seen <= n_seen;
                    r_fill <= n_fill;
                    if (r_cnt == LETTER_FIRST) begin
                        r_state <= ST_REV;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                ST_REV: begin
                    r_rev[r_fwd[r_cnt]] <= r_cnt;
                    if (r_cnt == LETTER_LAST) begin
                        r_state     <= ST_IDLE;
                        r_key_ready <= 1'b1;
                        r_cnt       <= LETTER_FIRST;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/kwsc_checker.sv =====
// ----------------------------------------------------------------------------
// kwsc_checker
// port-level assertions for the keyword substitution cipher
// ----------------------------------------------------------------------------
`include "keyword_substitution_cipher_assert.svh"

module kwsc_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input kwsc_pkg::t_mode i_mode,
    input kwsc_pkg::t_byte i_data_byte,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input kwsc_pkg::t_byte o_out_byte,
    input logic            o_no_key,
    input logic            i_cfg_valid,
    input logic            o_cfg_ready
);
    import kwsc_pkg::*;

    logic in_acc;
    logic non_letter;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign non_letter = !((i_data_byte >= CH_UPPER_A) && (i_data_byte <= CH_UPPER_Z))
                     && !((i_data_byte >= CH_LOWER_A) && (i_data_byte <= CH_LOWER_Z));

    // stalled output word holds
    `KWSC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_byte) && $stable(o_no_key), "stalled output word changed")

    // text word gives a result next cycle
    `KWSC_ASSERT_NXT(a_text_result, i_clk, i_rst_n, in_acc && (i_mode == MODE_TEXT), o_out_valid, "text word gave no result")

    // non-letters pass unchanged
    `KWSC_ASSERT_NXT(a_non_letter, i_clk, i_rst_n, in_acc && (i_mode == MODE_TEXT) && non_letter, o_out_byte == $past(i_data_byte), "non-letter was altered")

    // key completion blocks the input
    `KWSC_ASSERT_NXT(a_end_busy, i_clk, i_rst_n, in_acc && (i_mode == MODE_END), o_in_stall, "input open during key completion")

    // config port never blocks
    `KWSC_ASSERT_IMP(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready, "config write refused")

endmodule

bind keyword_substitution_cipher kwsc_checker u_kwsc_checker (.*);
